/* rtl/bmp_pixel_array_decoder_core_defines.svh */
`ifndef BMP_PIXEL_ARRAY_DECODER_CORE_DEFINES_SVH
`define BMP_PIXEL_ARRAY_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPAD_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpad: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BPAD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bpad: next-cycle check failed");

`endif

/* rtl/bpad_pkg.sv */
`default_nettype none

package bpad_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    localparam int DIM_W = 13;
    localparam int COL_W = 16;
    localparam int ROW_W = 13;
    localparam int X_W   = 12;
    localparam int LEN_W = 8;
    localparam int RGB_W = 24;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_4  = 3'd1;
    localparam logic [2:0] DEPTH_8  = 3'd2;
    localparam logic [2:0] DEPTH_16 = 3'd3;
    localparam logic [2:0] DEPTH_24 = 3'd4;
    localparam logic [2:0] DEPTH_32 = 3'd5;

    localparam logic [1:0] COMP_NONE     = 2'd0;
    localparam logic [1:0] COMP_RLE8     = 2'd1;
    localparam logic [1:0] COMP_RLE4     = 2'd2;
    localparam logic [1:0] COMP_BITFIELD = 2'd3;

    localparam logic [2:0] CFG_DEPTH      = 3'd0;
    localparam logic [2:0] CFG_COMP       = 3'd1;
    localparam logic [2:0] CFG_WIDTH      = 3'd2;
    localparam logic [2:0] CFG_HEIGHT     = 3'd3;
    localparam logic [2:0] CFG_TOP_DOWN   = 3'd4;
    localparam logic [2:0] CFG_RED_MASK   = 3'd5;
    localparam logic [2:0] CFG_GREEN_MASK = 3'd6;
    localparam logic [2:0] CFG_BLUE_MASK  = 3'd7;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [6:0] {
        RP_COUNT = 7'b0000001,
        RP_ENC   = 7'b0000010,
        RP_ESC   = 7'b0000100,
        RP_DX    = 7'b0001000,
        RP_DY    = 7'b0010000,
        RP_ABS   = 7'b0100000,
        RP_PAD   = 7'b1000000
    } run_phase_t;

    typedef enum logic [1:0] {
        CS_ZERO,
        CS_PAL,
        CS_DIRECT
    } color_sel_t;

endpackage

`default_nettype wire

/* rtl/bmp_pixel_array_decoder_core.sv */
// Bitmap pixel array decoder.
// Input stream s_*: up to one request per cycle. s_tuser selects a palette
// write (0) or a pixel array byte (1). Palette entries are loaded first.
// Result stream m_*: one span per transfer; m_tlast marks the final span of
// a request, m_tuser carries image_done and out_of_bounds.
// Configuration port cfg_*: register writes, always ready, applied the next
// cycle; write only while no request is in flight.
// A span passes the palette read and the span stage, then the output
// register. Throughput: one request per cycle while m_tready is high, for
// palette writes and for all bytes that give at most one span; a 1-bit
// byte emits up to eight spans, one per cycle while m_tready is high, and
// holds s_tready low until its last span leaves the span stage.
// The palette lives in a 256-entry RAM with two read ports, read when a
// byte is accepted; its read registers hold those words for the span stage.
// Reset clears the decode state and loads the default configuration; the
// palette content is not cleared.
// When m_tready is low the output register holds, the span stage holds, and
// s_tready drops once the span stage is full.
`default_nettype none
`include "bmp_pixel_array_decoder_core_defines.svh"

module bmp_pixel_array_decoder_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // palette_index[7:0], palette_color[31:8], data_byte[39:32]
    input  wire logic [bpad_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation[0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // span_x[11:0], span_y[23:12], span_length[31:24],
    // color_even[55:32], color_odd[79:56]
    output logic      [bpad_pkg::OUT_DATA_W-1:0]     m_tdata,
    // image_done[0], out_of_bounds[1]
    output logic      [bpad_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bpad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bpad_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bpad_pkg::*;

    // Scale a masked channel to 8 bits.
    function automatic logic [7:0] channel(input logic [31:0] word, input logic [31:0] mask);
        logic [5:0]  sh;
        logic [5:0]  n;
        logic [31:0] m;
        logic [31:0] v;
        logic [7:0]  val;
        sh  = '0;
        n   = '0;
        val = '0;
        for (int i = 31; i >= 0; i--) begin
            if (mask[i]) sh = 6'(i);
        end
        m = mask >> sh;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) n = 6'(i + 1);
        end
        v = (word & mask) >> sh;
        case (n)
            6'd0: val = '0;
            6'd1: val = {8{v[0]}};
            6'd2: val = {4{v[1:0]}};
            6'd3: val = {v[2:0], v[2:0], v[2:1]};
            6'd4: val = {2{v[3:0]}};
            6'd5: val = {v[4:0], v[4:2]};
            6'd6: val = {v[5:0], v[5:4]};
            6'd7: val = {v[6:0], v[6]};
            default: val = 8'(v >> (n - 6'd8));
        endcase
        return val;
    endfunction

    // configuration
    logic [2:0]       depth_reg;
    logic [1:0]       comp_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             top_down_reg;
    logic [31:0]      red_mask_reg;
    logic [31:0]      green_mask_reg;
    logic [31:0]      blue_mask_reg;

    // decode state
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       phase_reg, phase_next;
    logic [23:0]      asm_reg, asm_next;
    logic [1:0]       cnt_reg, cnt_next;
    run_phase_t       rp_reg, rp_next;
    logic [7:0]       rc_reg, rc_next;
    logic [7:0]       ar_reg, ar_next;
    logic             done_reg, done_next;

    // span stage
    logic             s1_valid_reg;
    logic [3:0]       s1_n_reg;
    logic [2:0]       s1_k_reg;
    logic [X_W-1:0]   s1_x_reg;
    logic [X_W-1:0]   s1_y_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_oob_reg;
    logic             s1_done_reg;
    color_sel_t       s1_csel_reg;
    logic             s1_onebit_reg;
    logic [7:0]       s1_bits_reg;
    logic [RGB_W-1:0] s1_color_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    logic [RGB_W-1:0] pal_a;
    logic [RGB_W-1:0] pal_b;

    logic             in_accept;
    logic [PAL_AW-1:0] pal_idx;
    logic [RGB_W-1:0] pal_color;
    logic [7:0]       b;
    logic [2:0]       d_eff;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [COL_W-1:0] w_ext;
    logic             rle;
    logic             four;
    logic             plain_onebit;
    logic [PAL_AW-1:0] rd_addr_a;
    logic [PAL_AW-1:0] rd_addr_b;
    logic [31:0]      rm;
    logic [31:0]      gm;
    logic [31:0]      bm;
    logic [31:0]      word_full;
    logic [31:0]      word_px;
    logic [RGB_W-1:0] direct_color;

    logic             s1_fire;
    logic             s1_last;

    // stage-0 results
    logic             proc;
    logic             sp_en;
    logic [LEN_W-1:0] sp_len;
    color_sel_t       sp_csel;
    logic             sp_onebit;
    logic             new_row;
    logic             plain_tail;
    logic [COL_W-1:0] diff;
    logic [COL_W:0]   col_sum;
    logic [ROW_W-1:0] row_sum;
    logic [7:0]       ab_n;
    logic [7:0]       ar_dec;
    logic [8:0]       abs_bytes;
    logic [2:0]       need;
    logic             ld_valid;
    logic [3:0]       ld_n;
    logic [X_W-1:0]   ld_x;
    logic [X_W-1:0]   ld_y;
    logic [LEN_W-1:0] ld_len;
    logic             ld_oob;
    color_sel_t       ld_csel;
    logic             ld_onebit;

    // output selection
    logic [X_W-1:0]   o_x;
    logic [LEN_W-1:0] o_len;
    logic [RGB_W-1:0] o_even;
    logic [RGB_W-1:0] o_odd;

    assign in_accept = s_tvalid && s_tready;
    assign pal_idx   = s_tdata[PAL_AW-1:0];
    assign pal_color = s_tdata[31:8];
    assign b         = s_tdata[39:32];
    assign cfg_ready = 1'b1;

    assign d_eff = (depth_reg > DEPTH_32) ? DEPTH_32 : depth_reg;
    assign w_eff = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : height_reg;
    assign w_ext = COL_W'(w_eff);

    assign rle          = (comp_reg == COMP_RLE8) || (comp_reg == COMP_RLE4);
    assign plain_onebit = !rle && (d_eff == DEPTH_1);
    assign four         = (comp_reg == COMP_RLE4) || (!rle && (d_eff == DEPTH_4));

    always_comb begin
        if (plain_onebit) begin
            rd_addr_a = PAL_AW'(0);
            rd_addr_b = PAL_AW'(1);
        end else if (four) begin
            rd_addr_a = PAL_AW'(b[7:4]);
            rd_addr_b = PAL_AW'(b[3:0]);
        end else begin
            rd_addr_a = PAL_AW'(b);
            rd_addr_b = PAL_AW'(b);
        end
    end

    bpad_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk      (aclk),
        .wr_en     (in_accept && (s_tuser == OP_PALETTE)),
        .wr_addr   (pal_idx),
        .wr_data   (pal_color),
        .rd_en     (in_accept && (s_tuser == OP_DATA)),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (pal_a),
        .rd_data_b (pal_b)
    );

    // pixel word and its colour
    always_comb begin
        word_full = {8'd0, asm_reg} | ({24'd0, b} << {cnt_reg, 3'b000});
        if (comp_reg == COMP_BITFIELD) begin
            rm = red_mask_reg;
            gm = green_mask_reg;
            bm = blue_mask_reg;
        end else if (d_eff == DEPTH_16) begin
            rm = 32'h0000_7C00;
            gm = 32'h0000_03E0;
            bm = 32'h0000_001F;
        end else begin
            rm = 32'h00FF_0000;
            gm = 32'h0000_FF00;
            bm = 32'h0000_00FF;
        end
        word_px = (d_eff == DEPTH_16) ? (word_full & 32'h0000_FFFF) : word_full;
        if (d_eff == DEPTH_24) begin
            direct_color = word_full[23:0];
        end else begin
            direct_color = {channel(word_px, rm), channel(word_px, gm), channel(word_px, bm)};
        end
    end

    assign s1_last  = ({1'b0, s1_k_reg} == (s1_n_reg - 4'd1));
    assign s1_fire  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || (s1_fire && s1_last);

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        asm_next   = asm_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        rc_next    = rc_reg;
        ar_next    = ar_reg;
        done_next  = done_reg;
        proc       = 1'b0;
        sp_en      = 1'b0;
        sp_len     = '0;
        sp_csel    = CS_PAL;
        sp_onebit  = 1'b0;
        new_row    = 1'b0;
        plain_tail = 1'b0;
        diff       = w_ext - col_reg;
        col_sum    = '0;
        row_sum    = row_reg + ROW_W'(b);
        ab_n       = 8'd1;
        ar_dec     = '0;
        abs_bytes  = '0;
        need       = (d_eff == DEPTH_16) ? 3'd2 : (d_eff == DEPTH_24) ? 3'd3 : 3'd4;
        ld_valid   = 1'b0;
        ld_n       = 4'd1;
        ld_x       = '0;
        ld_y       = '0;
        ld_len     = '0;
        ld_oob     = 1'b0;
        ld_csel    = CS_ZERO;
        ld_onebit  = 1'b0;

        if (in_accept && (s_tuser == OP_DATA)) begin
            if (done_reg || (row_reg >= ROW_W'(h_eff))) begin
                done_next = 1'b1;
            end else if (rle) begin
                proc = 1'b1;
                case (rp_reg)
                    RP_ENC: begin
                        sp_en   = 1'b1;
                        sp_len  = rc_reg;
                        rp_next = RP_COUNT;
                    end
                    RP_ESC: begin
                        rp_next = RP_COUNT;
                        if (b == ESC_EOL) begin
                            new_row = 1'b1;
                        end else if (b == ESC_EOB) begin
                            done_next = 1'b1;
                        end else if (b == ESC_DELTA) begin
                            rp_next = RP_DX;
                        end else begin
                            rc_next = b;
                            ar_next = b;
                            rp_next = RP_ABS;
                        end
                    end
                    RP_DX: begin
                        rc_next = b;
                        rp_next = RP_DY;
                    end
                    RP_DY: begin
                        col_sum  = {1'b0, col_reg} + (COL_W+1)'(rc_reg);
                        col_next = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];
                        row_next = row_sum;
                        if (row_sum >= ROW_W'(h_eff)) done_next = 1'b1;
                        rp_next  = RP_COUNT;
                    end
                    RP_ABS: begin
                        if (four && (ar_reg >= 8'd2)) ab_n = 8'd2;
                        sp_en   = 1'b1;
                        sp_len  = ab_n;
                        ar_dec  = ar_reg - ab_n;
                        ar_next = ar_dec;
                        if (ar_dec == '0) begin
                            abs_bytes = four ? (({1'b0, rc_reg} + 9'd1) >> 1) : {1'b0, rc_reg};
                            rp_next   = abs_bytes[0] ? RP_PAD : RP_COUNT;
                        end
                    end
                    RP_PAD: begin
                        rp_next = RP_COUNT;
                    end
                    default: begin
                        if (b != 8'd0) begin
                            rc_next = b;
                            rp_next = RP_ENC;
                        end else begin
                            rp_next = RP_ESC;
                        end
                    end
                endcase
            end else begin
                proc       = 1'b1;
                plain_tail = 1'b1;
                if (col_reg < w_ext) begin
                    case (d_eff)
                        DEPTH_1: begin
                            sp_en     = 1'b1;
                            sp_onebit = 1'b1;
                            sp_len    = (diff >= COL_W'(8)) ? 8'd8 : diff[7:0];
                        end
                        DEPTH_4: begin
                            sp_en  = 1'b1;
                            sp_len = (diff >= COL_W'(2)) ? 8'd2 : 8'd1;
                        end
                        DEPTH_8: begin
                            sp_en  = 1'b1;
                            sp_len = 8'd1;
                        end
                        default: begin
                            if (({1'b0, cnt_reg} + 3'd1) >= need) begin
                                asm_next = '0;
                                cnt_next = '0;
                                sp_en    = 1'b1;
                                sp_len   = 8'd1;
                                sp_csel  = CS_DIRECT;
                            end else begin
                                asm_next = word_full[23:0];
                                cnt_next = cnt_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
        end

        if (sp_en) begin
            ld_valid  = 1'b1;
            ld_onebit = sp_onebit;
            ld_n      = sp_onebit ? sp_len[3:0] : 4'd1;
            if (col_reg >= w_ext) begin
                ld_oob = 1'b1;
            end else begin
                ld_x    = col_reg[X_W-1:0];
                ld_y    = top_down_reg ? row_reg[X_W-1:0] : X_W'(h_eff - DIM_W'(1) - row_reg);
                ld_len  = ((COL_W'(sp_len)) > diff) ? diff[LEN_W-1:0] : sp_len;
                ld_csel = sp_csel;
            end
            col_sum  = {1'b0, col_reg} + (COL_W+1)'(sp_len);
            col_next = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];
        end

        if (plain_tail) begin
            phase_next = phase_reg + 2'd1;
            if ((col_next >= w_ext) && (phase_next == 2'd0)) new_row = 1'b1;
        end

        if (new_row) begin
            col_next   = '0;
            row_next   = row_reg + ROW_W'(1);
            phase_next = '0;
            asm_next   = '0;
            cnt_next   = '0;
            if ((row_reg + ROW_W'(1)) >= ROW_W'(h_eff)) done_next = 1'b1;
        end

        // image end with no span: status result
        if (proc && !sp_en && done_next) begin
            ld_valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= DEPTH_24;
            comp_reg       <= COMP_NONE;
            width_reg      <= DIM_W'(1);
            height_reg     <= DIM_W'(1);
            top_down_reg   <= 1'b0;
            red_mask_reg   <= 32'h00FF_0000;
            green_mask_reg <= 32'h0000_FF00;
            blue_mask_reg  <= 32'h0000_00FF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEPTH:      depth_reg      <= cfg_data[2:0];
                CFG_COMP:       comp_reg       <= cfg_data[1:0];
                CFG_WIDTH:      width_reg      <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:     height_reg     <= cfg_data[DIM_W-1:0];
                CFG_TOP_DOWN:   top_down_reg   <= cfg_data[0];
                CFG_RED_MASK:   red_mask_reg   <= cfg_data;
                CFG_GREEN_MASK: green_mask_reg <= cfg_data;
                CFG_BLUE_MASK:  blue_mask_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
            asm_reg   <= '0;
            cnt_reg   <= '0;
            rp_reg    <= RP_COUNT;
            rc_reg    <= '0;
            ar_reg    <= '0;
            done_reg  <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            asm_reg   <= asm_next;
            cnt_reg   <= cnt_next;
            rp_reg    <= rp_next;
            rc_reg    <= rc_next;
            ar_reg    <= ar_next;
            done_reg  <= done_next;
        end
    end

    // span stage: one request's spans, walked one per cycle while the output register can take them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_k_reg     <= '0;
        end else if (in_accept && ld_valid) begin
            s1_valid_reg <= 1'b1;
            s1_k_reg     <= '0;
        end else if (s1_fire && s1_last) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            s1_k_reg <= s1_k_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && ld_valid) begin
            s1_n_reg      <= ld_n;
            s1_x_reg      <= ld_x;
            s1_y_reg      <= ld_y;
            s1_len_reg    <= ld_len;
            s1_oob_reg    <= ld_oob;
            s1_done_reg   <= done_next;
            s1_csel_reg   <= ld_csel;
            s1_onebit_reg <= ld_onebit;
            s1_bits_reg   <= b;
            s1_color_reg  <= direct_color;
        end
    end

    always_comb begin
        o_x   = s1_onebit_reg ? (s1_x_reg + X_W'(s1_k_reg)) : s1_x_reg;
        o_len = s1_onebit_reg ? LEN_W'(1) : s1_len_reg;
        case (s1_csel_reg)
            CS_PAL: begin
                if (s1_onebit_reg) begin
                    o_even = s1_bits_reg[3'd7 - s1_k_reg] ? pal_b : pal_a;
                    o_odd  = o_even;
                end else begin
                    o_even = pal_a;
                    o_odd  = pal_b;
                end
            end
            CS_DIRECT: begin
                o_even = s1_color_reg;
                o_odd  = s1_color_reg;
            end
            default: begin
                o_even = '0;
                o_odd  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_tdata_reg <= {o_odd, o_even, o_len, s1_y_reg, o_x};
            m_tuser_reg <= {s1_oob_reg, s1_last && s1_done_reg};
            m_tlast_reg <= s1_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `BPAD_ASSERT_HOLDS(a_oob_empty, aclk, aresetn, m_tvalid_reg && m_tuser_reg[1], m_tdata_reg[31:24] == 8'd0)
    `BPAD_ASSERT_HOLDS(a_done_on_last, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0], m_tlast_reg)
    `BPAD_ASSERT_HOLDS(a_span_index, aclk, aresetn, s1_valid_reg, s1_k_reg < s1_n_reg)
    `BPAD_ASSERT_NEXT(a_done_sticky, aclk, aresetn, done_reg, done_reg)

endmodule

`default_nettype wire

/* rtl/bpad_ram.sv */
`default_nettype none

module bpad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

/* tb/tb_bmp_pixel_array_decoder_core.sv */
`default_nettype none

module tb_bmp_pixel_array_decoder_core;
    import bpad_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int unsigned COL_SAT = 65535;

    // decode phases of a compressed stream
    localparam int PH_COUNT = 0;
    localparam int PH_ENC   = 1;
    localparam int PH_ESC   = 2;
    localparam int PH_DX    = 3;
    localparam int PH_DY    = 4;
    localparam int PH_ABS   = 5;
    localparam int PH_PAD   = 6;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  len;
        logic [23:0] ce;
        logic [23:0] co;
        logic        done;
        logic        oob;
        logic        last;
    } span_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bmp_pixel_array_decoder_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // decoder shadow state
    logic [23:0] pal_mem [PALETTE_DEPTH];
    int unsigned col_pos, row_cnt, byte_phase, asm_word, asm_cnt;
    int unsigned run_ph, run_len, abs_left;
    bit          img_done;
    int unsigned depth_cfg, comp_cfg, width_cfg, height_cfg, top_down_cfg;
    logic [31:0] red_m, green_m, blue_m;

    span_t item_spans[$];
    span_t pending_spans[$];

    int errors = 0;
    int cycles = 0;
    int data_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    function automatic int unsigned eff_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    function automatic void add_span(int unsigned len, logic [23:0] ce, logic [23:0] co);
        span_t s;
        int unsigned w, l, h;
        w = eff_dim(width_cfg);
        h = eff_dim(height_cfg);
        s = '{default: '0};
        if (col_pos >= w) begin
            s.oob = 1'b1;
        end else begin
            l = (len > w - col_pos) ? w - col_pos : len;
            s.x = col_pos[11:0];
            s.y = top_down_cfg ? row_cnt[11:0] : 12'(h - 1 - row_cnt);
            s.len = l[7:0];
            s.ce = ce;
            s.co = co;
        end
        item_spans.push_back(s);
        col_pos += len;
        if (col_pos > COL_SAT) col_pos = COL_SAT;
    endfunction

    function automatic void advance_row();
        col_pos = 0;
        row_cnt++;
        byte_phase = 0;
        asm_word = 0;
        asm_cnt = 0;
        if (row_cnt >= eff_dim(height_cfg)) img_done = 1;
    endfunction

    function automatic logic [7:0] scale_channel(logic [31:0] word, logic [31:0] mask);
        int sh, n, pos;
        logic [31:0] v, val;
        if (mask == 0) return 8'h00;
        sh = 0;
        while (!mask[sh]) sh++;
        n = 0;
        while (n < 32 && ((mask >> sh) >> n) != 0) n++;
        v = (word & mask) >> sh;
        val = 0;
        pos = 8;
        while (pos > 0) begin
            if (pos >= n) begin
                pos -= n;
                val |= v << pos;
            end else begin
                val |= v >> (n - pos);
                pos = 0;
            end
        end
        return val[7:0];
    endfunction

    function automatic void decode_plain(logic [7:0] b);
        int unsigned w, d, need;
        logic [31:0] word, rm, gm, bm;
        logic [23:0] c;
        w = eff_dim(width_cfg);
        d = (depth_cfg > DEPTH_32) ? DEPTH_32 : depth_cfg;
        if (col_pos < w) begin
            if (d == DEPTH_1) begin
                for (int i = 7; i >= 0 && col_pos < w; i--) begin
                    c = pal_mem[b[i]];
                    add_span(1, c, c);
                end
            end else if (d == DEPTH_4) begin
                add_span((w - col_pos >= 2) ? 2 : 1, pal_mem[b[7:4]], pal_mem[b[3:0]]);
            end else if (d == DEPTH_8) begin
                add_span(1, pal_mem[b], pal_mem[b]);
            end else begin
                need = (d == DEPTH_16) ? 2 : (d == DEPTH_24) ? 3 : 4;
                if (asm_cnt + 1 >= need) begin
                    word = asm_word | (32'(b) << (8 * asm_cnt));
                    asm_word = 0;
                    asm_cnt = 0;
                    if (d == DEPTH_24) begin
                        c = word[23:0];
                    end else begin
                        if (comp_cfg == COMP_BITFIELD) begin
                            rm = red_m; gm = green_m; bm = blue_m;
                        end else if (d == DEPTH_16) begin
                            rm = 32'h7C00; gm = 32'h03E0; bm = 32'h001F;
                        end else begin
                            rm = 32'hFF0000; gm = 32'hFF00; bm = 32'hFF;
                        end
                        if (d == DEPTH_16) word &= 32'hFFFF;
                        c = {scale_channel(word, rm), scale_channel(word, gm),
                             scale_channel(word, bm)};
                    end
                    add_span(1, c, c);
                end else begin
                    asm_word = (asm_word | (32'(b) << (8 * asm_cnt))) & 32'hFFFFFF;
                    asm_cnt++;
                end
            end
        end
        byte_phase = (byte_phase + 1) & 3;
        if (col_pos >= w && byte_phase == 0) advance_row();
    endfunction

    function automatic void decode_run(logic [7:0] b, bit four);
        int unsigned n, nbytes;
        case (run_ph)
            PH_ENC: begin
                if (four) add_span(run_len, pal_mem[b[7:4]], pal_mem[b[3:0]]);
                else add_span(run_len, pal_mem[b], pal_mem[b]);
                run_ph = PH_COUNT;
            end
            PH_ESC: begin
                run_ph = PH_COUNT;
                if (b == ESC_EOL) advance_row();
                else if (b == ESC_EOB) img_done = 1;
                else if (b == ESC_DELTA) run_ph = PH_DX;
                else begin
                    run_len = b;
                    abs_left = b;
                    run_ph = PH_ABS;
                end
            end
            PH_DX: begin
                run_len = b;
                run_ph = PH_DY;
            end
            PH_DY: begin
                col_pos += run_len;
                if (col_pos > COL_SAT) col_pos = COL_SAT;
                row_cnt += b;
                if (row_cnt >= eff_dim(height_cfg)) img_done = 1;
                run_ph = PH_COUNT;
            end
            PH_ABS: begin
                if (four) begin
                    n = (abs_left >= 2) ? 2 : 1;
                    add_span(n, pal_mem[b[7:4]], pal_mem[b[3:0]]);
                    abs_left -= n;
                end else begin
                    add_span(1, pal_mem[b], pal_mem[b]);
                    abs_left--;
                end
                if (abs_left == 0) begin
                    nbytes = four ? (run_len + 1) >> 1 : run_len;
                    run_ph = nbytes[0] ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: run_ph = PH_COUNT;
            default: begin
                if (b != 0) begin
                    run_len = b;
                    run_ph = PH_ENC;
                end else begin
                    run_ph = PH_ESC;
                end
            end
        endcase
    endfunction

    function automatic void predict_request(logic op, logic [7:0] idx, logic [23:0] color,
                                            logic [7:0] b);
        span_t s;
        if (op == OP_PALETTE) begin
            pal_mem[idx] = color;
            return;
        end
        if (img_done || row_cnt >= eff_dim(height_cfg)) begin
            img_done = 1;
            return;
        end
        item_spans.delete();
        if (comp_cfg == COMP_RLE8) decode_run(b, 1'b0);
        else if (comp_cfg == COMP_RLE4) decode_run(b, 1'b1);
        else decode_plain(b);
        if (img_done && item_spans.size() == 0) begin
            s = '{default: '0};
            item_spans.push_back(s);
        end
        if (item_spans.size() > 0) begin
            item_spans[$].last = 1'b1;
            item_spans[$].done = img_done;
        end
        foreach (item_spans[i]) pending_spans.push_back(item_spans[i]);
    endfunction

    task automatic send_request(logic op, logic [7:0] idx, logic [23:0] color, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, color, idx};
        do @(posedge aclk); while (!s_tready);
        predict_request(op, idx, color, b);
        if (op == OP_DATA) data_sent++;
        @(negedge aclk);
    endtask

    // hold off an accidental end-of-bitmap escape so the image stays open
    task automatic send_byte(logic [7:0] b);
        if (comp_cfg != COMP_NONE && comp_cfg != COMP_BITFIELD && run_ph == PH_ESC &&
            b == ESC_EOB)
            b = 8'd3;
        send_request(OP_DATA, 8'h00, 24'h0, b);
    endtask

    // drop valid, wait until every expected span has left, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        // nothing may be in flight while a register changes
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEPTH:      depth_cfg = value[2:0];
            CFG_COMP:       comp_cfg = value[1:0];
            CFG_WIDTH:      width_cfg = value[12:0];
            CFG_HEIGHT:     height_cfg = value[12:0];
            CFG_TOP_DOWN:   top_down_cfg = value[0];
            CFG_RED_MASK:   red_m = value;
            CFG_GREEN_MASK: green_m = value;
            default:        blue_m = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_palette_load();
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            send_request(OP_PALETTE, 8'(i), 24'($urandom), 8'h00);
        end
        send_request(OP_PALETTE, 8'hFF, 24'hFFFFFF, 8'h00);
        send_request(OP_PALETTE, 8'h00, 24'h000000, 8'h00);
        drain();
    endtask

    task automatic test_plain_directed();
        write_reg(CFG_HEIGHT, 32'd8191);
        write_reg(CFG_TOP_DOWN, 32'd0);
        write_reg(CFG_COMP, 32'(COMP_NONE));
        write_reg(CFG_DEPTH, 32'(DEPTH_1));
        write_reg(CFG_WIDTH, 32'd5);
        // five pixels, then the row padding
        send_byte(8'hA5);
        repeat (3) send_byte(8'hFF);
        write_reg(CFG_DEPTH, 32'(DEPTH_4));
        write_reg(CFG_WIDTH, 32'd3);
        send_byte(8'h12);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
        write_reg(CFG_COMP, 32'(COMP_BITFIELD));
        write_reg(CFG_DEPTH, 32'(DEPTH_16));
        write_reg(CFG_RED_MASK, 32'h0000F800);
        write_reg(CFG_GREEN_MASK, 32'h000007E0);
        write_reg(CFG_BLUE_MASK, 32'h00000000);
        write_reg(CFG_WIDTH, 32'd0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        drain();
        write_reg(CFG_DEPTH, 32'(DEPTH_32));
        write_reg(CFG_RED_MASK, 32'hFFFFFFFF);
        write_reg(CFG_TOP_DOWN, 32'd1);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h01);
        drain();
        // unused depth code decodes as 32 bits per pixel
        write_reg(CFG_COMP, 32'(COMP_NONE));
        write_reg(CFG_DEPTH, 32'd7);
        write_reg(CFG_WIDTH, 32'd4096);
        repeat (4) send_byte(8'($urandom));
        drain();
    endtask

    task automatic test_rle_directed();
        write_reg(CFG_COMP, 32'(COMP_RLE8));
        write_reg(CFG_WIDTH, 32'd4);
        // encoded run clipped at the row end, then one that starts past it
        send_byte(8'd200); send_byte(8'd9);
        send_byte(8'd2);   send_byte(8'd10);
        send_byte(ESC_EOL); send_byte(ESC_EOL);
        send_byte(ESC_EOL); send_byte(ESC_DELTA); send_byte(8'd1); send_byte(8'd1);
        send_byte(ESC_EOL); send_byte(8'd3);
        send_byte(8'd4); send_byte(8'd5); send_byte(8'd6); send_byte(8'd0);
        drain();
        write_reg(CFG_COMP, 32'(COMP_RLE4));
        write_reg(CFG_TOP_DOWN, 32'd0);
        send_byte(8'd3); send_byte(8'h5A);
        send_byte(ESC_EOL); send_byte(8'd3);
        send_byte(8'hC3); send_byte(8'h70);
        drain();
    endtask

    task automatic random_rle_command(bit four);
        int kind, n;
        kind = $urandom_range(9);
        if (kind < 4) begin
            send_byte(8'($urandom_range(255, 2)));
            send_byte(8'($urandom));
        end else if (kind < 7) begin
            n = $urandom_range(12, 3);
            send_byte(ESC_EOL);
            send_byte(8'(n));
            n = four ? (n + 1) / 2 : n;
            repeat (n) send_byte(8'($urandom));
            if (n % 2) send_byte(8'h00);
        end else if (kind < 9) begin
            send_byte(ESC_EOL);
            send_byte(ESC_EOL);
        end else begin
            send_byte(ESC_EOL);
            send_byte(ESC_DELTA);
            send_byte(8'($urandom_range(6)));
            send_byte(8'($urandom_range(1)));
        end
    endtask

    task automatic random_mask(logic [2:0] idx);
        int lo, hi;
        case ($urandom_range(3))
            0: write_reg(idx, 32'h0);
            1: write_reg(idx, 32'hFFFFFFFF);
            2: write_reg(idx, $urandom);
            default: begin
                lo = $urandom_range(28);
                hi = $urandom_range(31, lo);
                write_reg(idx, (32'hFFFFFFFF >> (31 - hi)) & (32'hFFFFFFFF << lo));
            end
        endcase
    endtask

    task automatic test_random_images(int idle, int stall, int quota);
        int target, kind, w;
        target = data_sent + quota;
        idle_pct = idle;
        stall_pct = stall;
        while (data_sent < target) begin
            drain();
            kind = $urandom_range(3);
            w = $urandom_range(24, 1);
            case ($urandom_range(19))
                0: w = 0;
                1: w = 8191;
                2: w = 4096;
                default: ;
            endcase
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_TOP_DOWN, $urandom_range(1));
            if (kind < 2) begin
                write_reg(CFG_COMP, 32'(kind ? COMP_BITFIELD : COMP_NONE));
                write_reg(CFG_DEPTH, $urandom_range(7));
                if (kind) begin
                    random_mask(CFG_RED_MASK);
                    random_mask(CFG_GREEN_MASK);
                    random_mask(CFG_BLUE_MASK);
                end
                repeat ($urandom_range(24, 6)) begin
                    if ($urandom_range(15) == 0)
                        send_request(OP_PALETTE, 8'($urandom), 24'($urandom), 8'h00);
                    send_byte(8'($urandom));
                end
            end else begin
                write_reg(CFG_COMP, 32'((kind == 2) ? COMP_RLE8 : COMP_RLE4));
                repeat ($urandom_range(8, 3)) random_rle_command(kind == 3);
                // occasional stray byte out of step with the commands
                if ($urandom_range(3) == 0) send_byte(8'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_image_end();
        idle_pct = 20;
        stall_pct = 20;
        write_reg(CFG_COMP, 32'(COMP_RLE8));
        write_reg(CFG_TOP_DOWN, 32'd1);
        write_reg(CFG_WIDTH, 32'd16);
        write_reg(CFG_HEIGHT, row_cnt + 1);
        if (run_ph != PH_COUNT) send_byte(8'h00);
        send_byte(8'd5);
        send_byte(8'd7);
        send_request(OP_DATA, 8'h00, 24'h0, ESC_EOL);
        send_request(OP_DATA, 8'h00, 24'h0, ESC_EOB);
        // bytes past the image end give nothing
        repeat (3) send_request(OP_DATA, 8'h00, 24'h0, 8'($urandom));
        drain();
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : span_check
        span_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spans.size() == 0) begin
                $error("span with no request pending: %h", m_tdata);
                errors++;
            end else begin
                want = pending_spans.pop_front();
                check_field("span_x", 24'(want.x), 24'(m_tdata[11:0]));
                check_field("span_y", 24'(want.y), 24'(m_tdata[23:12]));
                check_field("span_length", 24'(want.len), 24'(m_tdata[31:24]));
                check_field("color_even", want.ce, m_tdata[55:32]);
                check_field("color_odd", want.co, m_tdata[79:56]);
                check_field("image_done", 24'(want.done), 24'(m_tuser[0]));
                check_field("out_of_bounds", 24'(want.oob), 24'(m_tuser[1]));
                check_field("last_of_item", 24'(want.last), 24'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bmp_pixel_array_decoder_core: mismatch");
            $finish;
        end
    end

    initial begin
        col_pos = 0; row_cnt = 0; byte_phase = 0; asm_word = 0; asm_cnt = 0;
        run_ph = PH_COUNT; run_len = 0; abs_left = 0; img_done = 0;
        depth_cfg = DEPTH_24; comp_cfg = COMP_NONE; width_cfg = 1; height_cfg = 1;
        top_down_cfg = 0;
        red_m = 32'hFF0000; green_m = 32'hFF00; blue_m = 32'hFF;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_palette_load();
        test_plain_directed();
        test_rle_directed();
        test_random_images(34, 84, 85);
        test_random_images(84, 34, 85);
        test_random_images(0, 0, 85);
        test_image_end();
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("bmp_pixel_array_decoder_core: match");
        end else begin
            $display("bmp_pixel_array_decoder_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
